FILE: hw/rtl/boc_pkg.sv
// boc_pkg: shared constants for the box obstacle clearance block.
// No dependencies.
package boc_pkg;
    localparam int FRAC_BITS = 16;
    localparam int COORD_W = 24;
    localparam int HALF_W  = 23;
    localparam int OUT_W   = 21;
    localparam int GAP_W   = 26;
    localparam int SQ_W    = 54;
    localparam int ROOT_W  = 27;
    localparam int DIST_W  = 30;

    localparam logic [2:0] REG_MIN_X  = 3'd0;
    localparam logic [2:0] REG_MIN_Y  = 3'd1;
    localparam logic [2:0] REG_MIN_Z  = 3'd2;
    localparam logic [2:0] REG_MAX_X  = 3'd3;
    localparam logic [2:0] REG_MAX_Y  = 3'd4;
    localparam logic [2:0] REG_MAX_Z  = 3'd5;
    localparam logic [2:0] REG_MARGIN = 3'd6;
    localparam logic [2:0] REG_COUNT  = 3'd7;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef struct packed {
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic signed [COORD_W-1:0] cz;
        logic [HALF_W-1:0]         hx;
        logic [HALF_W-1:0]         hy;
        logic [HALF_W-1:0]         hz;
    } box_t;
endpackage

FILE: hw/rtl/box_obstacle_clearance_top.sv
// box_obstacle_clearance_top: top level of the clearance block.
// Uses boc_pkg, boc_ram, boc_gap_unit, boc_sqrt_cell.
//
// A write word (req_type 0) stores one box. A query word streams the first
// min(obstacle_count, MAX_BOXES) boxes from the table, one per cycle, through
// a gap/square stage pair and a chain of 27 square root cells, then folds in
// the workspace walls; busy is high until clearance is shown. The result is
// held on clearance, done high for one cycle; the receiver cannot stall it.
module box_obstacle_clearance_top #(
    parameter int MAX_BOXES = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        req_type,
    input  logic [3:0]  entry_index,
    input  logic signed [23:0] coord_x,
    input  logic signed [23:0] coord_y,
    input  logic signed [23:0] coord_z,
    input  logic [22:0] half_x,
    input  logic [22:0] half_y,
    input  logic [22:0] half_z,
    output logic        done,
    output logic signed [20:0] clearance,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int AW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam int CW = $clog2(MAX_BOXES + 1);
    localparam int NC = boc_pkg::ROOT_W;
    localparam int BW = $bits(boc_pkg::box_t);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    // configuration registers
    logic signed [23:0] min_reg [3];
    logic signed [23:0] max_reg [3];
    logic [16:0] margin_reg;
    logic [4:0]  count_reg;
    logic [2:0]  ridx;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign ridx   = paddr[4:2];
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg[0] <= -24'sd32768;
            min_reg[1] <= -24'sd58982;
            min_reg[2] <= 24'sd0;
            max_reg[0] <= 24'sd52429;
            max_reg[1] <= 24'sd58982;
            max_reg[2] <= 24'sd78643;
            margin_reg <= '0;
            count_reg  <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (ridx)
                boc_pkg::REG_MIN_X:  min_reg[0] <= pwdata[23:0];
                boc_pkg::REG_MIN_Y:  min_reg[1] <= pwdata[23:0];
                boc_pkg::REG_MIN_Z:  min_reg[2] <= pwdata[23:0];
                boc_pkg::REG_MAX_X:  max_reg[0] <= pwdata[23:0];
                boc_pkg::REG_MAX_Y:  max_reg[1] <= pwdata[23:0];
                boc_pkg::REG_MAX_Z:  max_reg[2] <= pwdata[23:0];
                boc_pkg::REG_MARGIN: margin_reg <= pwdata[16:0];
                boc_pkg::REG_COUNT:  count_reg  <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (ridx)
            boc_pkg::REG_MIN_X:  prdata = 32'(unsigned'(min_reg[0]));
            boc_pkg::REG_MIN_Y:  prdata = 32'(unsigned'(min_reg[1]));
            boc_pkg::REG_MIN_Z:  prdata = 32'(unsigned'(min_reg[2]));
            boc_pkg::REG_MAX_X:  prdata = 32'(unsigned'(max_reg[0]));
            boc_pkg::REG_MAX_Y:  prdata = 32'(unsigned'(max_reg[1]));
            boc_pkg::REG_MAX_Z:  prdata = 32'(unsigned'(max_reg[2]));
            boc_pkg::REG_MARGIN: prdata = 32'(margin_reg);
            default:             prdata = 32'(count_reg);
        endcase
    end

    // control
    logic [1:0]  state_reg, state_next;
    logic [CW-1:0] n_reg, n_next, issue_reg, issue_next;
    logic [5:0]  drain_reg, drain_next;
    logic        accept, issue_vld, rd_vld_reg;
    logic signed [23:0] px_reg, py_reg, pz_reg;
    logic [4:0]  nsel;
    logic        tbl_we;
    boc_pkg::box_t wbox, rbox;

    assign accept = start && !busy;
    assign busy   = (state_reg != ST_IDLE);
    assign nsel   = (32'(count_reg) > MAX_BOXES) ? 5'(MAX_BOXES) : count_reg;
    assign tbl_we = accept && (req_type == boc_pkg::REQ_WRITE)
                 && (32'(entry_index) < MAX_BOXES);
    assign wbox   = '{coord_x, coord_y, coord_z, half_x, half_y, half_z};
    assign issue_vld = (state_reg == ST_RUN) && (issue_reg < n_reg);

    boc_ram #(.WIDTH(BW), .DEPTH(MAX_BOXES)) u_table (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (AW'(entry_index)),
        .wdata (wbox),
        .raddr (AW'(issue_reg)),
        .rdata (rbox)
    );

    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        issue_next = issue_reg;
        drain_next = drain_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && req_type == boc_pkg::REQ_QUERY)
                begin
                    state_next = ST_RUN;
                    n_next     = CW'(nsel);
                    issue_next = '0;
                end
            end
            ST_RUN:
            begin
                if (issue_reg < n_reg)
                    issue_next = issue_reg + 1'b1;
                else
                begin
                    state_next = ST_FIN;
                    drain_next = 6'(NC + 3);
                end
            end
            ST_FIN:
            begin
                if (drain_reg == '0)
                    state_next = ST_IDLE;
                else
                    drain_next = drain_reg - 1'b1;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            n_reg      <= '0;
            issue_reg  <= '0;
            drain_reg  <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            n_reg      <= n_next;
            issue_reg  <= issue_next;
            drain_reg  <= drain_next;
            rd_vld_reg <= issue_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            px_reg <= coord_x;
            py_reg <= coord_y;
            pz_reg <= coord_z;
        end
    end

    // distance datapath: gap unit then chain of root cells
    logic                       g_vld;
    logic [boc_pkg::SQ_W-1:0]   g_sum;
    logic                       c_vld  [NC+1];
    logic [boc_pkg::SQ_W-1:0]   c_rem  [NC+1];
    logic [boc_pkg::ROOT_W-1:0] c_root [NC+1];

    boc_gap_unit u_gap (
        .clk     (clk),
        .rst_n   (rst_n),
        .vld_in  (rd_vld_reg),
        .box     (rbox),
        .px      (px_reg),
        .py      (py_reg),
        .pz      (pz_reg),
        .vld_out (g_vld),
        .sum_sq  (g_sum)
    );

    assign c_vld[0]  = g_vld;
    assign c_rem[0]  = g_sum;
    assign c_root[0] = '0;

    for (genvar i = 0; i < NC; i++)
    begin : g_cell
        boc_sqrt_cell #(.STEP(i)) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .vld_in   (c_vld[i]),
            .rem_in   (c_rem[i]),
            .root_in  (c_root[i]),
            .vld_out  (c_vld[i+1]),
            .rem_out  (c_rem[i+1]),
            .root_out (c_root[i+1])
        );
    end

    // running minimum
    logic signed [boc_pkg::DIST_W-1:0] best_reg, cand, margin_s;
    assign margin_s = boc_pkg::DIST_W'(margin_reg);
    assign cand = boc_pkg::DIST_W'(c_root[NC]) - margin_s;

    // workspace walls
    logic signed [25:0] emin [3];
    logic signed [25:0] emax [3];
    logic signed [25:0] pv   [3];
    logic               outside;
    logic signed [boc_pkg::DIST_W-1:0] face, fin;

    assign pv[0] = 26'(px_reg);
    assign pv[1] = 26'(py_reg);
    assign pv[2] = 26'(pz_reg);

    always_comb
    begin
        outside = 1'b0;
        face    = best_reg;
        for (int a = 0; a < 3; a++)
        begin
            emin[a] = 26'(min_reg[a]) + 26'(margin_reg);
            emax[a] = 26'(max_reg[a]) - 26'(margin_reg);
            if (pv[a] < emin[a] || pv[a] > emax[a])
                outside = 1'b1;
            else
            begin
                if (boc_pkg::DIST_W'(pv[a] - emin[a]) < face)
                    face = boc_pkg::DIST_W'(pv[a] - emin[a]);
                if (boc_pkg::DIST_W'(emax[a] - pv[a]) < face)
                    face = boc_pkg::DIST_W'(emax[a] - pv[a]);
            end
        end
        if (outside)
            fin = (best_reg < 0) ? best_reg : '0;
        else
            fin = face;
    end

    logic last;
    assign last = (state_reg == ST_FIN) && (drain_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done <= 1'b0;
        end
        else
        begin
            done <= last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            best_reg <= boc_pkg::DIST_W'(10 << boc_pkg::FRAC_BITS);
        else if (c_vld[NC] && cand < best_reg)
            best_reg <= cand;
        if (last)
        begin
            if (fin < -boc_pkg::DIST_W'(1 << boc_pkg::FRAC_BITS))
                clearance <= -boc_pkg::OUT_W'(1 << boc_pkg::FRAC_BITS);
            else
                clearance <= boc_pkg::OUT_W'(fin);
        end
    end
endmodule

FILE: hw/rtl/boc_ram.sv
// boc_ram: generic simple dual-port RAM (one write, one read port) with registered read.
// No dependencies.
module boc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: hw/rtl/boc_sqrt_cell.sv
// boc_sqrt_cell: one stage of the restoring square root chain; one result bit
// a cell. Uses boc_pkg.
module boc_sqrt_cell #(
    parameter int STEP = 0
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       vld_in,
    input  logic [boc_pkg::SQ_W-1:0]   rem_in,
    input  logic [boc_pkg::ROOT_W-1:0] root_in,
    output logic                       vld_out,
    output logic [boc_pkg::SQ_W-1:0]   rem_out,
    output logic [boc_pkg::ROOT_W-1:0] root_out
);
    localparam int SH = 2 * (boc_pkg::ROOT_W - 1 - STEP);
    logic [boc_pkg::SQ_W+1:0] trial;
    logic [boc_pkg::SQ_W+1:0] remw;

    always_comb
    begin
        remw  = {2'b00, rem_in};
        trial = ({2'b00, boc_pkg::SQ_W'(root_in)} << (SH + 2))
              | ({{(boc_pkg::SQ_W+1){1'b0}}, 1'b1} << SH);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_out <= 1'b0;
        else
            vld_out <= vld_in;
    end

    always_ff @(posedge clk)
    begin
        if (remw >= trial)
        begin
            rem_out  <= boc_pkg::SQ_W'(remw - trial);
            root_out <= {root_in[boc_pkg::ROOT_W-2:0], 1'b1};
        end
        else
        begin
            rem_out  <= rem_in;
            root_out <= {root_in[boc_pkg::ROOT_W-2:0], 1'b0};
        end
    end
endmodule

FILE: hw/rtl/boc_gap_unit.sv
// boc_gap_unit: axis gaps, squares and their sum for one box, two register
// stages. Uses boc_pkg.
module boc_gap_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               vld_in,
    input  boc_pkg::box_t                      box,
    input  logic signed [boc_pkg::COORD_W-1:0] px,
    input  logic signed [boc_pkg::COORD_W-1:0] py,
    input  logic signed [boc_pkg::COORD_W-1:0] pz,
    output logic                               vld_out,
    output logic [boc_pkg::SQ_W-1:0]           sum_sq
);
    logic [boc_pkg::GAP_W-1:0] gx, gy, gz;
    logic [2*boc_pkg::GAP_W-1:0] sx_reg, sy_reg, sz_reg;
    logic vld_reg;

    function automatic logic [boc_pkg::GAP_W-1:0] gap(
        input logic signed [boc_pkg::COORD_W-1:0] p,
        input logic signed [boc_pkg::COORD_W-1:0] c,
        input logic [boc_pkg::HALF_W-1:0] h);
        logic signed [boc_pkg::GAP_W:0] lo, hi, pp, g;
        begin
            pp = (boc_pkg::GAP_W+1)'(p);
            lo = (boc_pkg::GAP_W+1)'(c) - $signed({4'b0, h});
            hi = (boc_pkg::GAP_W+1)'(c) + $signed({4'b0, h});
            if (pp < lo)
                g = lo - pp;
            else if (pp > hi)
                g = pp - hi;
            else
                g = '0;
            gap = boc_pkg::GAP_W'(g);
        end
    endfunction

    always_comb
    begin
        gx = gap(px, box.cx, box.hx);
        gy = gap(py, box.cy, box.hy);
        gz = gap(pz, box.cz, box.hz);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
            vld_out <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_in;
            vld_out <= vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sx_reg  <= gx * gx;
        sy_reg  <= gy * gy;
        sz_reg  <= gz * gz;
        sum_sq  <= boc_pkg::SQ_W'(sx_reg) + boc_pkg::SQ_W'(sy_reg)
                 + boc_pkg::SQ_W'(sz_reg);
    end
endmodule
